/* src/roi_max_pooling_defines.svh */
// Assertion macros shared by the block's modules.
`ifndef ROI_MAX_POOLING_DEFINES_SVH
`define ROI_MAX_POOLING_DEFINES_SVH
// An implication checked at every clock edge outside reset.
`define RMP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// A condition checked in the cycle after its trigger.
`define RMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/rmp_pkg.sv */
package rmp_pkg;
  localparam int MAX_BATCH    = 2;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_WIDTH    = 64;
  localparam int MAX_POOLED   = 8;
  localparam int BW = 1;
  localparam int CW = 4;
  localparam int RW = 6;
  localparam int KW = 6;
  localparam int ADDR_W = BW + CW + RW + KW;
  localparam int DEPTH = MAX_BATCH * MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    REG_BATCH = 3'd0, REG_CHAN = 3'd1, REG_MH = 3'd2, REG_MW = 3'd3,
    REG_PH = 3'd4, REG_PW = 3'd5, REG_SCALE = 3'd6
  } reg_idx_t;

  // Clamped configuration as the datapath uses it.
  typedef struct packed {
    logic [1:0]  nb;
    logic [4:0]  nc;
    logic [6:0]  mh;
    logic [6:0]  mw;
    logic [3:0]  ph;
    logic [3:0]  pw;
    logic [16:0] scale;
  } cfg_t;

  // One classified pool job handed from front to back.
  typedef struct packed {
    logic        err;
    logic [BW-1:0] b;
    logic [CW-1:0] c;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [11:0] ex;
    logic [11:0] ey;
  } job_t;

  // Store write port from front to back.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } wr_t;
endpackage

/* src/roi_max_pooling.sv */
// ROI max pooling. in_ words carry either a feature load (func 0) written
// into the on-chip map at once, or a pool request (func 1) queued for the
// back end. A load is held off while any pool is queued or running, so it
// never changes cells that an earlier pool still reads. A pool first scales
// its four corners, then for each bin sets up four bounds in turn and finds
// each by a subtractive divider, one quotient step at a time (up to about
// 4100 steps worst case), then reads the store once per covered cell and
// emits the bin's result once the output register is free. The single store
// read port sets the scan rate. Results leave on
// out_ in row-major bin order, last on the final bin; a bad batch or
// channel gives one word with error and last set. A four-entry queue lets
// new requests enter while the back end works. When the receiver stalls
// the result register holds and the back end waits; the queue then fills
// and in_tready drops. Reset clears control and the configuration to its
// defaults; map contents are undefined until loaded. Configuration writes
// are taken in any cycle and are meant for idle periods.
module roi_max_pooling (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: batch_index, channel, row, col, feature_value, roi_start_x,
  // roi_start_y, roi_end_x, roi_end_y (lowest first), zero to 88 bits
  input  logic [87:0] in_tdata,
  // tuser: func
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: pooled_value, bin_row, bin_col, zero to 24 bits
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  // tuser: error
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import rmp_pkg::*;

  logic [1:0]  nb_r;
  logic [4:0]  nc_r;
  logic [6:0]  mh_r, mw_r;
  logic [3:0]  ph_r, pw_r;
  logic [16:0] sc_r;
  cfg_t cfg;
  wr_t  wr;
  job_t job;
  logic job_valid, job_pop, back_busy;
  logic [15:0] pv;
  logic [2:0] br, bc;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r <= 2'd1; nc_r <= 5'd16; mh_r <= 7'd64; mw_r <= 7'd64;
      ph_r <= 4'd7; pw_r <= 4'd7; sc_r <= 17'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BATCH: nb_r <= cfg_data[1:0];
        REG_CHAN:  nc_r <= cfg_data[4:0];
        REG_MH:    mh_r <= cfg_data[6:0];
        REG_MW:    mw_r <= cfg_data[6:0];
        REG_PH:    ph_r <= cfg_data[3:0];
        REG_PW:    pw_r <= cfg_data[3:0];
        REG_SCALE: sc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Registers as used, clamped to their legal ranges.
  always_comb begin
    cfg.nb = (nb_r == 2'd0) ? 2'd1 : (nb_r > 2'(MAX_BATCH)) ? 2'(MAX_BATCH) : nb_r;
    cfg.nc = (nc_r == 5'd0) ? 5'd1 : (nc_r > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : nc_r;
    cfg.mh = (mh_r == 7'd0) ? 7'd1 : (mh_r > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : mh_r;
    cfg.mw = (mw_r == 7'd0) ? 7'd1 : (mw_r > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : mw_r;
    cfg.ph = (ph_r == 4'd0) ? 4'd1 : (ph_r > 4'(MAX_POOLED)) ? 4'(MAX_POOLED) : ph_r;
    cfg.pw = (pw_r == 4'd0) ? 4'd1 : (pw_r > 4'(MAX_POOLED)) ? 4'(MAX_POOLED) : pw_r;
    cfg.scale = sc_r[16] ? 17'd65536 : sc_r;
  end

  rmp_front u_front (
    .clk, .rst_n, .cfg,
    .in_valid(in_tvalid), .in_ready(in_tready), .func(in_tuser),
    .batch_index(in_tdata[1:0]), .channel(in_tdata[5:2]),
    .row(in_tdata[11:6]), .col(in_tdata[17:12]),
    .feature_value(in_tdata[33:18]),
    .sx(in_tdata[45:34]), .sy(in_tdata[57:46]),
    .ex(in_tdata[69:58]), .ey(in_tdata[81:70]),
    .wr, .job_valid, .job, .job_pop, .back_busy
  );

  rmp_back u_back (
    .clk, .rst_n, .cfg, .wr, .job_valid, .job, .job_pop, .busy(back_busy),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .pooled_value(pv), .bin_row(br), .bin_col(bc),
    .last(out_tlast), .error(out_tuser)
  );

  assign out_tdata = {2'b00, bc, br, pv};
endmodule

/* src/rmp_front.sv */
module rmp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  rmp_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          func,
  input  logic [1:0]    batch_index,
  input  logic [3:0]    channel,
  input  logic [5:0]    row,
  input  logic [5:0]    col,
  input  logic [15:0]   feature_value,
  input  logic [11:0]   sx,
  input  logic [11:0]   sy,
  input  logic [11:0]   ex,
  input  logic [11:0]   ey,
  output rmp_pkg::wr_t  wr,
  output logic          job_valid,
  output rmp_pkg::job_t job,
  input  logic          job_pop,
  input  logic          back_busy
);
  import rmp_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  job_t          q_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          acc, push, okb, okc;

  // A load waits until no pool is queued or running, so it never changes
  // cells that an earlier pool still has to read.
  assign in_ready  = (cnt_r != (PW+1)'(QDEPTH)) && (func || (cnt_r == '0 && !back_busy));
  assign acc       = in_valid && in_ready;
  assign push      = acc && func;
  assign job_valid = cnt_r != '0;
  assign job       = q_r[rp_r];
  assign okb       = {1'b0, batch_index} < {1'b0, cfg.nb};
  assign okc       = {1'b0, channel} < cfg.nc;

  // Loads go straight to the store when inside the configured map.
  always_comb begin
    wr.en   = acc && !func && okb && okc && ({1'b0, row} < cfg.mh) && ({1'b0, col} < cfg.mw);
    wr.addr = {batch_index[BW-1:0], channel, row, col};
    wr.data = feature_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{err: !(okb && okc), b: batch_index[BW-1:0], c: channel,
                     sx: sx, sy: sy, ex: ex, ey: ey};
    end
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (job_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(job_pop);
    end
  end

  `include "roi_max_pooling_defines.svh"
  `RMP_ASSERT_IMP(a_pop_nonempty, job_pop, job_valid, "pop of empty queue")
  `RMP_ASSERT_IMP(a_no_overflow, push, cnt_r < (PW+1)'(QDEPTH), "queue overflow")
  `RMP_ASSERT_IMP(a_load_no_push, wr.en, !push, "load pushed a job")
endmodule

/* src/rmp_back.sv */
module rmp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rmp_pkg::cfg_t cfg,
  input  rmp_pkg::wr_t  wr,
  input  logic          job_valid,
  input  rmp_pkg::job_t job,
  output logic          job_pop,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   pooled_value,
  output logic [2:0]    bin_row,
  output logic [2:0]    bin_col,
  output logic          last,
  output logic          error
);
  import rmp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_BIN, S_DIV, S_SCAN, S_EMIT
  } state_t;

  state_t state_r;
  logic [15:0] mem [DEPTH];
  logic [15:0] rd_r;
  logic        rdv_r;
  logic [BW-1:0] b_r;
  logic [CW-1:0] c_r;
  logic [1:0]  sc_r;           // which corner is scaled
  logic [12:0] sx_r, sy_r, ex_r, ey_r;
  logic [12:0] rh_r, rw_r;
  logic [2:0]  i_r, j_r;
  logic [1:0]  dsel_r;         // which bin bound is divided
  logic [16:0] num_r;          // dividend of running division
  logic [12:0] qt_r;           // quotient by repeated subtraction
  logic [13:0] hs_r, he_r, ws_r, we_r;
  logic [6:0]  h_r, w_r;
  logic signed [15:0] best_r;
  logic        any_r;
  logic [15:0] ov_r;
  logic [2:0]  orow_r, ocol_r;
  logic        olast_r, oerr_r, ovalid_r;

  logic [11:0] craw;
  logic [29:0] prod;
  logic [12:0] cs;
  logic [3:0]  dv;
  logic [16:0] qnext;
  logic [13:0] bnd, lim, bclamp;
  logic        bin_last;

  // Memory port: write from loads, one read per scan cycle.
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rd_r <= mem[{b_r, c_r, h_r[RW-1:0], w_r[KW-1:0]}];
  end

  always_comb begin
    unique case (sc_r)
      2'd0: craw = job.sx;
      2'd1: craw = job.sy;
      2'd2: craw = job.ex;
      default: craw = job.ey;
    endcase
    prod = {18'd0, craw} * {13'd0, cfg.scale} + 30'd32768;
    cs   = prod[28:16];
    dv   = dsel_r[1] ? cfg.pw : cfg.ph;
    qnext = num_r - {13'd0, dv};
    // Bound = origin + quotient, clamped to the map size.
    bnd = {1'b0, (dsel_r[1] ? sx_r : sy_r)} + {1'b0, qt_r};
    lim = dsel_r[1] ? {7'd0, cfg.mw} : {7'd0, cfg.mh};
    bclamp = (bnd > lim) ? lim : bnd;
    bin_last = ({1'b0, i_r} + 4'd1 == cfg.ph) && ({1'b0, j_r} + 4'd1 == cfg.pw);
  end

  assign job_pop      = state_r == S_IDLE && job_valid && job.err && !ovalid_r ||
                        state_r == S_SCALE && sc_r == 2'd3;
  assign busy         = state_r != S_IDLE;
  assign out_valid    = ovalid_r;
  assign pooled_value = ov_r;
  assign bin_row      = orow_r;
  assign bin_col      = ocol_r;
  assign last         = olast_r;
  assign error        = oerr_r;

  // Sequencer: scale corners, divide bin bounds, scan cells, emit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      rdv_r    <= 1'b0;
    end else begin
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      rdv_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (job_valid && !ovalid_r) begin
            if (job.err) begin
              ov_r <= '0; orow_r <= '0; ocol_r <= '0;
              olast_r <= 1'b1; oerr_r <= 1'b1; ovalid_r <= 1'b1;
            end else begin
              b_r <= job.b; c_r <= job.c; sc_r <= 2'd0;
              state_r <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          unique case (sc_r)
            2'd0: sx_r <= cs;
            2'd1: sy_r <= cs;
            2'd2: ex_r <= cs;
            default: ey_r <= cs;
          endcase
          sc_r <= sc_r + 2'd1;
          if (sc_r == 2'd3) begin
            rw_r <= (ex_r >= sx_r) ? ex_r - sx_r + 13'd1 : 13'd1;
            rh_r <= (cs >= sy_r) ? cs - sy_r + 13'd1 : 13'd1;
            i_r <= '0; j_r <= '0;
            dsel_r <= 2'd0;
            state_r <= S_BIN;
          end
        end
        S_BIN: begin
          // Set up one bound: floor(r*k/p) or ceil(r*(k+1)/p).
          unique case (dsel_r)
            2'd0: num_r <= 17'(rh_r * i_r);
            2'd1: num_r <= 17'(rh_r * (i_r + 4'd1) + cfg.ph - 4'd1);
            2'd2: num_r <= 17'(rw_r * j_r);
            default: num_r <= 17'(rw_r * (j_r + 4'd1) + cfg.pw - 4'd1);
          endcase
          qt_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (num_r >= {13'd0, dv}) begin
            num_r <= qnext; qt_r <= qt_r + 13'd1;
          end else begin
            unique case (dsel_r)
              2'd0: hs_r <= bclamp;
              2'd1: he_r <= bclamp;
              2'd2: ws_r <= bclamp;
              default: we_r <= bclamp;
            endcase
            dsel_r <= dsel_r + 2'd1;
            if (dsel_r == 2'd3) begin
              h_r <= hs_r[6:0]; w_r <= ws_r[6:0];
              best_r <= '0; any_r <= 1'b0;
              state_r <= (he_r > hs_r && bclamp > ws_r) ? S_SCAN : S_EMIT;
            end else begin
              state_r <= S_BIN;
            end
          end
        end
        S_SCAN: begin
          if (rdv_r) begin
            if (!any_r || $signed(rd_r) > best_r) best_r <= $signed(rd_r);
            any_r <= 1'b1;
          end
          if (!rdv_r || !(rdv_r && {7'd0, h_r} == he_r)) begin
            if ({7'd0, h_r} < he_r) begin
              rdv_r <= 1'b1;
              if ({7'd0, w_r} + 14'd1 == we_r) begin
                w_r <= ws_r[6:0]; h_r <= h_r + 7'd1;
              end else begin
                w_r <= w_r + 7'd1;
              end
            end else begin
              state_r <= S_EMIT;
            end
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ovalid_r) begin
            ov_r <= best_r; orow_r <= i_r; ocol_r <= j_r;
            olast_r <= bin_last; oerr_r <= 1'b0; ovalid_r <= 1'b1;
            if (bin_last) begin
              state_r <= S_IDLE;
            end else begin
              if ({1'b0, j_r} + 4'd1 == cfg.pw) begin
                j_r <= '0; i_r <= i_r + 3'd1;
              end else begin
                j_r <= j_r + 3'd1;
              end
              state_r <= S_BIN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "roi_max_pooling_defines.svh"
  `RMP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(pooled_value),
                   "result dropped while stalled")
  `RMP_ASSERT_IMP(a_err_last, out_valid && error, last, "error result not last")
  `RMP_ASSERT_IMP(a_scan_bounds, state_r == S_SCAN && rdv_r, he_r <= 14'd64,
                  "scan beyond map")
endmodule

/* sim/roi_max_pooling_tb.sv */
`timescale 1ns / 100ps

module roi_max_pooling_tb;
  import rmp_pkg::*;

  // One input word as the sender sees it.
  typedef struct {
    bit        func;
    bit [1:0]  b;
    bit [3:0]  c;
    bit [5:0]  r;
    bit [5:0]  k;
    bit [15:0] v;
    bit [11:0] sx;
    bit [11:0] sy;
    bit [11:0] ex;
    bit [11:0] ey;
  } roi_req_t;

  // One result word.
  typedef struct {
    bit [15:0] val;
    bit [2:0]  row;
    bit [2:0]  col;
    bit        last;
    bit        err;
  } bin_res_t;

  // Predicts the pooled bins of each accepted request from its own map copy.
  class roi_pool_model;
    bit [15:0] fmap [DEPTH];
    bit        loaded [DEPTH];
    bit [16:0] regs [7];
    bin_res_t  bins_due [$];

    function new();
      regs[REG_BATCH] = 1;  regs[REG_CHAN] = 16; regs[REG_MH] = 64;
      regs[REG_MW] = 64;    regs[REG_PH] = 7;    regs[REG_PW] = 7;
      regs[REG_SCALE] = 4096;
    endfunction

    function void write_reg(reg_idx_t idx, bit [16:0] val);
      case (idx)
        REG_BATCH: regs[idx] = val & 17'h3;
        REG_CHAN:  regs[idx] = val & 17'h1F;
        REG_MH, REG_MW: regs[idx] = val & 17'h7F;
        REG_PH, REG_PW: regs[idx] = val & 17'hF;
        default: regs[idx] = val;
      endcase
    endfunction

    // Register value as the datapath uses it.
    function int used(reg_idx_t idx);
      int lim;
      int v;
      case (idx)
        REG_BATCH: lim = MAX_BATCH;
        REG_CHAN:  lim = MAX_CHANNELS;
        REG_MH:    lim = MAX_HEIGHT;
        REG_MW:    lim = MAX_WIDTH;
        REG_SCALE: lim = 65536;
        default:   lim = MAX_POOLED;
      endcase
      v = regs[idx];
      if (idx != REG_SCALE && v < 1) v = 1;
      return (v > lim) ? lim : v;
    endfunction

    function int addr(int b, int c, int r, int k);
      return ((b * MAX_CHANNELS + c) * MAX_HEIGHT + r) * MAX_WIDTH + k;
    endfunction

    function int scaled(bit [11:0] x);
      return int'((longint'(x) * used(REG_SCALE) + 32768) >> 16);
    endfunction

    function int clip(int v, int hi);
      return (v < 0) ? 0 : (v > hi) ? hi : v;
    endfunction

    function int pending();
      return bins_due.size();
    endfunction

    function void accept(roi_req_t q);
      int nb, nc, mh, mw, ph, pw, sx, sy, ex, ey, rh, rw, hs, he, ws, we, best;
      bin_res_t o;
      nb = used(REG_BATCH); nc = used(REG_CHAN); mh = used(REG_MH);
      mw = used(REG_MW);    ph = used(REG_PH);   pw = used(REG_PW);
      if (!q.func) begin
        if (q.b < nb && q.c < nc && q.r < mh && q.k < mw) begin
          fmap[addr(q.b, q.c, q.r, q.k)] = q.v;
          loaded[addr(q.b, q.c, q.r, q.k)] = 1;
        end
        return;
      end
      if (q.b >= nb || q.c >= nc) begin
        o = '{val: 0, row: 0, col: 0, last: 1, err: 1};
        bins_due.push_back(o);
        return;
      end
      sx = scaled(q.sx); sy = scaled(q.sy);
      ex = scaled(q.ex); ey = scaled(q.ey);
      rh = ey - sy + 1; if (rh < 1) rh = 1;
      rw = ex - sx + 1; if (rw < 1) rw = 1;
      for (int i = 0; i < ph; i++) begin
        hs = clip(sy + (rh * i) / ph, mh);
        he = clip(sy + (rh * (i + 1) + ph - 1) / ph, mh);
        for (int j = 0; j < pw; j++) begin
          ws = clip(sx + (rw * j) / pw, mw);
          we = clip(sx + (rw * (j + 1) + pw - 1) / pw, mw);
          best = 0;
          if (he > hs && we > ws) begin
            best = -40000;
            for (int h = hs; h < he; h++)
              for (int w = ws; w < we; w++)
                if ($signed(fmap[addr(q.b, q.c, h, w)]) > best)
                  best = $signed(fmap[addr(q.b, q.c, h, w)]);
          end
          o.val = best[15:0]; o.row = i; o.col = j;
          o.last = (i == ph - 1 && j == pw - 1); o.err = 0;
          bins_due.push_back(o);
        end
      end
    endfunction

    // Returns an empty string on a match, else a description.
    function string check(bin_res_t got);
      bin_res_t e;
      if (bins_due.size() == 0)
        return $sformatf("unexpected word val=%h row=%0d col=%0d", got.val, got.row, got.col);
      e = bins_due.pop_front();
      if (got != e)
        return $sformatf("got val=%h row=%0d col=%0d last=%0d err=%0d, want %h %0d %0d %0d %0d",
                         got.val, got.row, got.col, got.last, got.err,
                         e.val, e.row, e.col, e.last, e.err);
      return "";
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  roi_pool_model model;
  int  errors;
  bit  tx_steady;
  bit  rx_steady;
  int  rx_hold;

  roi_max_pooling u_top (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic report(string msg);
    $display("MISMATCH %s", msg);
    errors++;
  endtask

  // Sends one word, after a random gap unless quick or steady, and notes it once accepted.
  task automatic send(roi_req_t q, bit quick);
    int gap;
    bit [87:0] pk;
    gap = (quick || tx_steady) ? 0 : $urandom_range(0, 12);
    pk = {6'd0, q.ey, q.ex, q.sy, q.sx, q.v, q.k, q.r, q.c, q.b};
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1;
    in_tdata  <= pk;
    in_tuser  <= q.func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model.accept(q);
  endtask

  task automatic stop_sending();
    @(negedge clk) in_tvalid <= 0;
  endtask

  task automatic write_reg(reg_idx_t idx, bit [16:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model.write_reg(idx, val);
    @(negedge clk) cfg_valid <= 0;
  endtask

  // Waits for every due bin, then lets the block settle.
  task automatic drain();
    stop_sending();
    while (model.pending() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_all(int nb, int nc, int mh, int mw, int ph, int pw, int sc);
    write_reg(REG_BATCH, nb); write_reg(REG_CHAN, nc);
    write_reg(REG_MH, mh);    write_reg(REG_MW, mw);
    write_reg(REG_PH, ph);    write_reg(REG_PW, pw);
    write_reg(REG_SCALE, sc);
  endtask

  // Loads every map cell that a pool under the current setting can read.
  task automatic fill_map();
    roi_req_t q;
    for (int b = 0; b < model.used(REG_BATCH); b++)
      for (int c = 0; c < model.used(REG_CHAN); c++)
        for (int r = 0; r < model.used(REG_MH); r++)
          for (int k = 0; k < model.used(REG_MW); k++)
            if (!model.loaded[model.addr(b, c, r, k)]) begin
              q = '{func: 0, b: b, c: c, r: r, k: k, v: $urandom, default: 0};
              send(q, 1);
            end
  endtask

  function automatic roi_req_t pool_req(int b, int c, int sx, int sy, int ex, int ey);
    return '{func: 1, b: b, c: c, r: $urandom, k: $urandom, v: $urandom,
             sx: sx, sy: sy, ex: ex, ey: ey};
  endfunction

  // Random word: mostly pools within range, some loads and bad requests.
  function automatic roi_req_t rand_req(int cmax);
    roi_req_t q;
    int nb, nc;
    nb = model.used(REG_BATCH);
    nc = model.used(REG_CHAN);
    q = pool_req(0, 0, $urandom_range(0, cmax), $urandom_range(0, cmax),
                 $urandom_range(0, cmax), $urandom_range(0, cmax));
    q.b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(0, nb - 1);
    q.c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, nc - 1);
    if ($urandom_range(0, 3) == 0) begin
      q.func = 0;
      q.b = $urandom_range(0, 3);
    end
    return q;
  endfunction

  // Result side: random stalls, plus one long hold on request.
  initial begin
    bin_res_t got;
    string msg;
    int n;
    out_tready = 0;
    forever begin
      if (rx_hold > 0) begin
        @(negedge clk) out_tready <= 0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      n = rx_steady ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        @(negedge clk) out_tready <= 0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.val = out_tdata[15:0]; got.row = out_tdata[18:16];
      got.col = out_tdata[21:19]; got.last = out_tlast; got.err = out_tuser;
      msg = model.check(got);
      if (msg != "") report(msg);
    end
  end

  initial begin
    #400_000_000;
    $display("roi_max_pooling_tb NOT OK");
    $finish;
  end

  // Stimulus.
  initial begin
    int cmax;
    model = new();
    errors = 0; tx_steady = 0; rx_steady = 0; rx_hold = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = 0;
    cfg_valid = 0; cfg_index = REG_BATCH; cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // Directed: small map, unit scale.
    set_all(2, 2, 4, 4, 2, 2, 65536);
    fill_map();
    send('{func: 0, b: 0, c: 0, r: 0, k: 0, v: 16'h8000, default: 0}, 0);
    send('{func: 0, b: 1, c: 1, r: 3, k: 3, v: 16'h7FFF, default: 0}, 0);
    send('{func: 0, b: 3, c: 15, r: 63, k: 63, v: 16'h5555, default: 0}, 0);
    send('{func: 0, b: 1, c: 2, r: 0, k: 0, v: 16'h1234, default: 0}, 0);
    send(pool_req(0, 0, 0, 0, 7, 7), 0);
    send(pool_req(1, 1, 0, 0, 7, 7), 0);
    send(pool_req(0, 1, 7, 6, 2, 1), 0);
    send(pool_req(0, 0, 4095, 4095, 4095, 4095), 0);
    send(pool_req(1, 0, 5, 3, 20, 9), 0);
    send(pool_req(2, 0, 0, 0, 7, 7), 0);
    send(pool_req(3, 1, 0, 0, 7, 7), 0);
    send(pool_req(0, 2, 0, 0, 7, 7), 0);
    send(pool_req(1, 15, 0, 0, 7, 7), 0);
    drain();

    // Half-up rounding of the corners.
    write_reg(REG_SCALE, 32768);
    send(pool_req(0, 0, 1, 3, 13, 15), 0);
    send(pool_req(1, 1, 0, 0, 1, 1), 0);
    drain();

    // Smallest map, all counts saturated, zero scale.
    set_all(3, 31, 0, 1, 8, 8, 0);
    fill_map();
    send(pool_req(1, 15, 4095, 4095, 4095, 4095), 0);
    send(pool_req(0, 0, 0, 0, 0, 0), 0);
    send(pool_req(1, 0, 100, 0, 3000, 2000), 0);
    drain();

    // Full-height map with one channel; register values past their limits.
    set_all(0, 0, 127, 2, 0, 15, 131071);
    fill_map();
    for (int n = 0; n < 8; n++) send(rand_req(80), 0);
    drain();
    write_reg(REG_SCALE, 1024);
    write_reg(REG_PH, 8);
    for (int n = 0; n < 8; n++) send(rand_req(4095), 0);
    drain();

    // Random settings with random content.
    for (int ph = 0; ph < 8; ph++) begin
      set_all($urandom_range(0, 3), $urandom_range(0, 2), $urandom_range(1, 4),
              $urandom_range(1, 4), $urandom_range(0, 9), $urandom_range(0, 9),
              $urandom_range(1, 2048));
      if (ph == 5) write_reg(REG_SCALE, 65536);
      cmax = (ph == 5) ? 24 : 4095;
      tx_steady = (ph == 2);
      rx_steady = (ph == 3);
      fill_map();
      if (ph == 1) rx_hold = 3000;
      for (int n = 0; n < 12; n++) begin
        send(rand_req(cmax), 0);
        if (ph == 4 && n == 6) begin
          stop_sending();
          while (model.pending() > 0) @(posedge clk);
        end
      end
      drain();
    end
    tx_steady = 0; rx_steady = 0;

    repeat (200) @(posedge clk);
    if (errors == 0 && model.pending() == 0)
      $display("roi_max_pooling_tb OK");
    else
      $display("roi_max_pooling_tb NOT OK");
    $finish;
  end
endmodule
